// ===== rtl/cht_pkg.sv =====
// Shared codes and controller/datapath interface types for the chained hash table.
package cht_pkg;

    localparam int OP_W  = 2;
    localparam int ST_W  = 2;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    localparam logic [OP_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [OP_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic            clr_step;
        logic            load;
        logic            init_walk;
        logic            take_free;
        logic            pop_free;
        logic            take_fresh;
        logic            ins_write;
        logic            advance;
        logic            unlink;
        logic            relink;
        logic            set_result;
        logic [ST_W-1:0] res_code;
        logic            res_use_value;
        logic            push_out;
    } cht_cmd_t;

    typedef struct packed {
        logic            clr_last;
        logic            mod_done;
        logic [OP_W-1:0] op;
        logic            free_valid;
        logic            fresh_avail;
        logic            cur_valid;
        logic            steps_done;
        logic            key_match;
        logic            prev_valid;
        logic            out_free;
    } cht_stat_t;

endpackage

// ===== rtl/cht_mod.sv =====
// Bucket index unit: key modulo the bucket count, by mask or reciprocal multiplication.
module cht_mod
    import cht_pkg::*;
#(
    parameter int BUCKETS = 64
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [KEY_W-1:0]                          key,
    output logic                                      done,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    generate
        if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
            logic          done_reg;
            logic [BW-1:0] bucket_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    bucket_reg <= key[BW-1:0] & BW'(BUCKETS - 1);
                end
            end

            assign done   = done_reg;
            assign bucket = bucket_reg;
        end
        else begin : g_recip
            localparam logic [KEY_W-1:0] RECIP =
                KEY_W'(((64'd1 << (KEY_W + BW)) / 64'(BUCKETS)) + 64'd1);

            logic                 mul_vld_reg;
            logic                 quo_vld_reg;
            logic                 rem_vld_reg;
            logic                 done_reg;
            logic [KEY_W-1:0]     x_reg;
            logic [KEY_W-1:0]     prod_hi_reg;
            logic [BW-1:0]        q_reg;
            logic [BW-1:0]        rem_reg;
            logic [2*KEY_W-1:0]   prod;
            logic [KEY_W:0]       upper;
            logic [BW-1:0]        qd;

            assign prod  = {{KEY_W{1'b0}}, x_reg} * {{KEY_W{1'b0}}, RECIP};
            assign upper = {1'b0, x_reg} + {1'b0, prod_hi_reg};
            assign qd    = q_reg * BW'(BUCKETS);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    mul_vld_reg <= 1'b0;
                    quo_vld_reg <= 1'b0;
                    rem_vld_reg <= 1'b0;
                    done_reg    <= 1'b0;
                end
                else
                begin
                    mul_vld_reg <= start;
                    quo_vld_reg <= mul_vld_reg;
                    rem_vld_reg <= quo_vld_reg;
                    done_reg    <= rem_vld_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    x_reg <= key;
                end
                if (mul_vld_reg)
                begin
                    prod_hi_reg <= prod[2*KEY_W-1:KEY_W];
                end
                if (quo_vld_reg)
                begin
                    q_reg <= upper[BW +: BW];
                end
                if (rem_vld_reg)
                begin
                    rem_reg <= x_reg[BW-1:0] - qd;
                end
            end

            assign done   = done_reg;
            assign bucket = rem_reg;
        end
    endgenerate

endmodule

// ===== rtl/cht_datapath.sv =====
// Datapath: bucket head memory, node pool memories, allocation and result registers.
module cht_datapath
    import cht_pkg::*;
#(
    parameter int BUCKETS = 64,
    parameter int NODES   = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [2*KEY_W-1:0]     s_tdata,
    input  logic [OP_W-1:0]        s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [VAL_W-1:0]       m_tdata,
    output logic [ST_W-1:0]        m_tuser,
    input  cht_cmd_t               ctl,
    output cht_stat_t              sts
);

    localparam int NW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [NW-1:0] EMPTY = NW'(NODES);

    logic [NW-1:0]    heads_mem [BUCKETS];
    logic [KEY_W-1:0] keys_mem  [NODES];
    logic [VAL_W-1:0] vals_mem  [NODES];
    logic [NW-1:0]    links_mem [NODES];

    logic [OP_W-1:0]  op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic [NW-1:0]    cur_reg;
    logic [NW-1:0]    prev_reg;
    logic [NW-1:0]    steps_reg;
    logic [NW-1:0]    free_head_reg;
    logic [NW-1:0]    fresh_reg;
    logic [BW-1:0]    clr_reg;
    logic [ST_W-1:0]  res_status_reg;
    logic [VAL_W-1:0] res_found_reg;
    logic             m_tvalid_reg;
    logic [ST_W-1:0]  out_status_reg;
    logic [VAL_W-1:0] out_found_reg;

    logic [NW-1:0]    head_rd_reg;
    logic [KEY_W-1:0] key_rd_reg;
    logic [VAL_W-1:0] val_rd_reg;
    logic [NW-1:0]    link_rd_reg;

    logic             mod_done;
    logic [BW-1:0]    bucket;

    logic             head_we;
    logic [BW-1:0]    head_waddr;
    logic [NW-1:0]    head_wdata;
    logic             link_we;
    logic [AW-1:0]    link_waddr;
    logic [NW-1:0]    link_wdata;

    cht_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctl.load),
        .key    (s_tdata[KEY_W-1:0]),
        .done   (mod_done),
        .bucket (bucket)
    );

    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = bucket;
        head_wdata = cur_reg;
        if (ctl.clr_step)
        begin
            head_we    = 1'b1;
            head_waddr = clr_reg;
            head_wdata = EMPTY;
        end
        else if (ctl.ins_write)
        begin
            head_we = 1'b1;
        end
        else if (ctl.unlink && !sts.prev_valid)
        begin
            head_we    = 1'b1;
            head_wdata = link_rd_reg;
        end
    end

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = cur_reg[AW-1:0];
        link_wdata = head_rd_reg;
        if (ctl.ins_write)
        begin
            link_we = 1'b1;
        end
        else if (ctl.unlink && sts.prev_valid)
        begin
            link_we    = 1'b1;
            link_waddr = prev_reg[AW-1:0];
            link_wdata = link_rd_reg;
        end
        else if (ctl.relink)
        begin
            link_we    = 1'b1;
            link_wdata = free_head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            heads_mem[head_waddr] <= head_wdata;
        end
        head_rd_reg <= heads_mem[bucket];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ins_write)
        begin
            keys_mem[cur_reg[AW-1:0]] <= key_reg;
            vals_mem[cur_reg[AW-1:0]] <= value_reg;
        end
        if (link_we)
        begin
            links_mem[link_waddr] <= link_wdata;
        end
        key_rd_reg  <= keys_mem[cur_reg[AW-1:0]];
        val_rd_reg  <= vals_mem[cur_reg[AW-1:0]];
        link_rd_reg <= links_mem[cur_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            fresh_reg     <= '0;
            free_head_reg <= EMPTY;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clr_step)
            begin
                clr_reg <= clr_reg + BW'(1);
            end
            if (ctl.take_fresh)
            begin
                fresh_reg <= fresh_reg + NW'(1);
            end
            if (ctl.pop_free)
            begin
                free_head_reg <= link_rd_reg;
            end
            else if (ctl.relink)
            begin
                free_head_reg <= cur_reg;
            end
            if (ctl.push_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg    <= s_tuser;
            key_reg   <= s_tdata[KEY_W-1:0];
            value_reg <= s_tdata[2*KEY_W-1:KEY_W];
        end
        if (ctl.init_walk)
        begin
            cur_reg   <= head_rd_reg;
            prev_reg  <= EMPTY;
            steps_reg <= '0;
        end
        else if (ctl.take_free)
        begin
            cur_reg <= free_head_reg;
        end
        else if (ctl.take_fresh)
        begin
            cur_reg <= fresh_reg;
        end
        else if (ctl.advance)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= link_rd_reg;
            steps_reg <= steps_reg + NW'(1);
        end
        if (ctl.set_result)
        begin
            res_status_reg <= ctl.res_code;
            res_found_reg  <= ctl.res_use_value ? val_rd_reg : '0;
        end
        if (ctl.push_out)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
        end
    end

    assign sts.clr_last    = (clr_reg == BW'(BUCKETS - 1));
    assign sts.mod_done    = mod_done;
    assign sts.op          = op_reg;
    assign sts.free_valid  = (free_head_reg < EMPTY);
    assign sts.fresh_avail = (fresh_reg < EMPTY);
    assign sts.cur_valid   = (cur_reg < EMPTY);
    assign sts.steps_done  = (steps_reg == EMPTY);
    assign sts.key_match   = (key_rd_reg == key_reg);
    assign sts.prev_valid  = (prev_reg < EMPTY);
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_found_reg;
    assign m_tuser  = out_status_reg;

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= EMPTY)
        else $error("fresh count beyond pool size");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push_out |-> (!m_tvalid_reg || m_tready))
        else $error("result pushed over a pending one");

    a_ins_node: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins_write |-> (cur_reg < EMPTY))
        else $error("insert writes an invalid node");

    a_relink_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.relink |=> (free_head_reg == $past(cur_reg)))
        else $error("released node not at free list head");

endmodule

// ===== rtl/cht_ctrl.sv =====
// Controller: sequences clear, bucket, allocation, chain walk and result push.
module cht_ctrl
    import cht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  cht_stat_t sts,
    output cht_cmd_t  ctl
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_MOD       = 4'd2;
    localparam logic [3:0] S_HEAD      = 4'd3;
    localparam logic [3:0] S_DISPATCH  = 4'd4;
    localparam logic [3:0] S_FREE_WAIT = 4'd5;
    localparam logic [3:0] S_FREE_RD   = 4'd6;
    localparam logic [3:0] S_INS_WR    = 4'd7;
    localparam logic [3:0] S_CHECK     = 4'd8;
    localparam logic [3:0] S_NODE_WAIT = 4'd9;
    localparam logic [3:0] S_COMPARE   = 4'd10;
    localparam logic [3:0] S_UNLINK    = 4'd11;
    localparam logic [3:0] S_RELINK    = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (sts.mod_done)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    CMD_LOOKUP, CMD_REMOVE:
                    begin
                        ctl.init_walk = 1'b1;
                        state_next    = S_CHECK;
                    end
                    CMD_INSERT:
                    begin
                        if (sts.free_valid)
                        begin
                            ctl.take_free = 1'b1;
                            state_next    = S_FREE_WAIT;
                        end
                        else if (sts.fresh_avail)
                        begin
                            ctl.take_fresh = 1'b1;
                            state_next     = S_INS_WR;
                        end
                        else
                        begin
                            ctl.set_result = 1'b1;
                            ctl.res_code   = ST_FULL;
                            state_next     = S_DONE;
                        end
                    end
                    default:
                    begin
                        ctl.set_result = 1'b1;
                        ctl.res_code   = ST_OK;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_FREE_WAIT:
            begin
                state_next = S_FREE_RD;
            end
            S_FREE_RD:
            begin
                ctl.pop_free = 1'b1;
                state_next   = S_INS_WR;
            end
            S_INS_WR:
            begin
                ctl.ins_write  = 1'b1;
                ctl.set_result = 1'b1;
                ctl.res_code   = ST_OK;
                state_next     = S_DONE;
            end
            S_CHECK:
            begin
                if (!sts.cur_valid || sts.steps_done)
                begin
                    ctl.set_result = 1'b1;
                    ctl.res_code   = ST_NOT_FOUND;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_NODE_WAIT;
                end
            end
            S_NODE_WAIT:
            begin
                state_next = S_COMPARE;
            end
            S_COMPARE:
            begin
                if (!sts.key_match)
                begin
                    ctl.advance = 1'b1;
                    state_next  = S_CHECK;
                end
                else if (sts.op == CMD_REMOVE)
                begin
                    state_next = S_UNLINK;
                end
                else
                begin
                    ctl.set_result    = 1'b1;
                    ctl.res_code      = ST_OK;
                    ctl.res_use_value = 1'b1;
                    state_next        = S_DONE;
                end
            end
            S_UNLINK:
            begin
                ctl.unlink = 1'b1;
                state_next = S_RELINK;
            end
            S_RELINK:
            begin
                ctl.relink     = 1'b1;
                ctl.set_result = 1'b1;
                ctl.res_code   = ST_OK;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.push_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/chained_hash_table.sv =====
// Top level of the chained hash table: controller plus datapath.
//
// Requests enter on the s_ channel (s_tuser = cmd, s_tdata = key, value) and
// each one yields exactly one response on the m_ channel (m_tuser = status,
// m_tdata = found value, zero unless a lookup hit).
// After reset the block sweeps the bucket head memory, one bucket per cycle,
// over every bucket; s_tready stays low until the sweep ends.
// One request is processed at a time. The bucket index comes from a mask for
// a power-of-two BUCKETS, else from a reciprocal multiply in the remainder
// unit. An insert takes a released node from the free list when one is
// available, else a fresh node; a lookup or remove walks the chain node by
// node, and a remove hit unlinks the node and returns it to the free list.
// The chain walk is bound by the node memory read port: each node passes through S_CHECK, S_NODE_WAIT and S_COMPARE.
// A new request is taken in the cycle after the previous response is pushed into
// the output register, even while m_tready is low; if the output register is
// still occupied when the next response is ready, the block holds it until
// the receiver takes the pending response.
module chained_hash_table
    import cht_pkg::*;
#(
    parameter int BUCKETS = 64,
    parameter int NODES   = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2*KEY_W-1:0]   s_tdata,   // key [31:0], value [63:32]
    input  logic [OP_W-1:0]      s_tuser,   // cmd [1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [VAL_W-1:0]     m_tdata,   // found_value [31:0]
    output logic [ST_W-1:0]      m_tuser    // status [1:0]
);

    cht_cmd_t  ctl;
    cht_stat_t sts;

    cht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    cht_datapath #(
        .BUCKETS (BUCKETS),
        .NODES   (NODES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .ctl      (ctl),
        .sts      (sts)
    );

endmodule
